// ----- src/dwps_pkg.sv -----
`default_nettype none

package dwps_pkg;

    localparam int unsigned PWM_MAX_DEF     = 999;
    localparam int unsigned TICK_DIVIDE_DEF = 2;

    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int MODE_W    = 2;
    localparam int CHAN_W    = 10;
    localparam int INTEG_W   = 24;
    localparam int ERR_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_SH   = 12;

    localparam int ERR_LIM   = 800;
    localparam int INTEG_LIM = 2457600;

    localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PROP_GAIN   = 3'd0;
    localparam t_cfg_idx CFG_INTEG_GAIN  = 3'd1;
    localparam t_cfg_idx CFG_LEFT_DIRINV = 3'd2;
    localparam t_cfg_idx CFG_RIGHT_DIRINV = 3'd3;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_target;
        logic signed [SPEED_W-1:0] right_target;
        logic [MODE_W-1:0]         control_mode;
        logic                      unlocked;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] left_chan_one;
        logic [CHAN_W-1:0] left_chan_two;
        logic [CHAN_W-1:0] right_chan_one;
        logic [CHAN_W-1:0] right_chan_two;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
    } t_gains;

endpackage

`default_nettype wire

// ----- src/dual_wheel_pi_speed_hbridge.sv -----
// An accepted transaction is held in the input register, then in the result
// register that drives o_out_valid. One transaction per cycle while the output
// does not stall; the PI update of both wheels is combinational between them.
// Reset (i_rst_n low, synchronous): gains, direction selects, tick counter,
// integrals and stored drives clear to zero; both pipeline registers empty.
`default_nettype none

module dual_wheel_pi_speed_hbridge #(
    parameter int unsigned PWM_MAX     = dwps_pkg::PWM_MAX_DEF,
    parameter int unsigned TICK_DIVIDE = dwps_pkg::TICK_DIVIDE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire dwps_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output dwps_pkg::t_out_item                 o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire dwps_pkg::t_cfg_idx             i_cfg_index,
    input  wire logic [dwps_pkg::GAIN_W-1:0]    i_cfg_data
);
    import dwps_pkg::*;

    localparam int DRV_W = $clog2(PWM_MAX + 1) + 1;
    localparam int PH_W  = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(TICK_DIVIDE - 1);

    t_gains           r_gains;
    logic             r_left_inv;
    logic             r_right_inv;
    logic [PH_W-1:0]  r_phase;
    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_out_valid;
    t_out_item        r_out;

    logic                     w_accept;
    logic                     w_fire;
    logic                     w_closed;
    logic                     w_wrap;
    logic                     w_update;
    logic                     w_enable;
    logic signed [DRV_W-1:0]  w_left_drv;
    logic signed [DRV_W-1:0]  w_right_drv;
    logic signed [DRV_W-1:0]  w_left_sel;
    logic signed [DRV_W-1:0]  w_right_sel;
    t_out_item                w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains     <= '0;
            r_left_inv  <= 1'b0;
            r_right_inv <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:    r_gains.prop_gain  <= i_cfg_data;
                CFG_INTEG_GAIN:   r_gains.integ_gain <= i_cfg_data;
                CFG_LEFT_DIRINV:  r_left_inv         <= i_cfg_data[0];
                CFG_RIGHT_DIRINV: r_right_inv        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_closed   = (r_in.control_mode == MODE_CLOSED);
    assign w_wrap     = (r_phase == PH_LAST);
    assign w_update   = w_fire && w_closed && w_wrap;
    assign w_enable   = w_closed && r_in.unlocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_fire && w_closed) begin
            r_phase <= w_wrap ? '0 : r_phase + 1'b1;
        end
    end

    dwps_pi_wheel #(.PWM_MAX(PWM_MAX)) u_left_pi (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_speed  (r_in.left_speed),
        .i_target (r_in.left_target),
        .i_gains  (r_gains),
        .i_update (w_update),
        .o_drive  (w_left_drv)
    );

    dwps_pi_wheel #(.PWM_MAX(PWM_MAX)) u_right_pi (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_speed  (r_in.right_speed),
        .i_target (r_in.right_target),
        .i_gains  (r_gains),
        .i_update (w_update),
        .o_drive  (w_right_drv)
    );

    assign w_left_sel  = w_enable ? w_left_drv : '0;
    assign w_right_sel = w_enable ? w_right_drv : '0;

    dwps_hbridge #(.PWM_MAX(PWM_MAX)) u_left_hb (
        .i_drive      (w_left_sel),
        .i_pos_on_one (!r_left_inv),
        .o_chan_one   (w_result.left_chan_one),
        .o_chan_two   (w_result.left_chan_two)
    );

    dwps_hbridge #(.PWM_MAX(PWM_MAX)) u_right_hb (
        .i_drive      (w_right_sel),
        .i_pos_on_one (r_right_inv),
        .o_chan_one   (w_result.right_chan_one),
        .o_chan_two   (w_result.right_chan_two)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- src/dwps_pi_wheel.sv -----
`default_nettype none

module dwps_pi_wheel #(
    parameter int unsigned PWM_MAX = dwps_pkg::PWM_MAX_DEF,
    localparam int DRV_W = $clog2(PWM_MAX + 1) + 1
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic signed [dwps_pkg::SPEED_W-1:0]     i_speed,
    input  wire logic signed [dwps_pkg::SPEED_W-1:0]     i_target,
    input  wire dwps_pkg::t_gains                        i_gains,
    input  wire logic                                    i_update,
    output logic signed [DRV_W-1:0]                      o_drive
);
    import dwps_pkg::*;

    localparam int DIFF_W = SPEED_W + 1;
    localparam int PROD_W = GAIN_W + ERR_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int OUT_W  = 30;
    localparam int MAG_W  = DRV_W - 1;

    localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(ERR_LIM);
    localparam logic signed [DIFF_W-1:0] DIFF_LO = -DIFF_HI;
    localparam logic signed [ACC_W-1:0]  ACC_HI  = ACC_W'(INTEG_LIM);
    localparam logic signed [ACC_W-1:0]  ACC_LO  = -ACC_HI;
    localparam logic signed [OUT_W-1:0]  OUT_HI  = OUT_W'(PWM_MAX * 4096);
    localparam logic signed [OUT_W-1:0]  OUT_LO  = -OUT_HI;

    logic signed [INTEG_W-1:0] r_int;
    logic signed [INTEG_W-1:0] n_int;
    logic signed [DRV_W-1:0]   r_drive;
    logic signed [DRV_W-1:0]   n_drive;

    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [PROD_W-1:0]  w_iprod;
    logic signed [PROD_W-1:0]  w_pprod;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [OUT_W-1:0]   w_out;
    logic signed [OUT_W-1:0]   w_outc;
    logic                      w_neg;
    logic [OUT_W-1:0]          w_abs;
    logic [MAG_W-1:0]          w_mag;
    logic [DRV_W-1:0]          w_pos;

    always_comb begin
        w_diff = {i_target[SPEED_W-1], i_target} - {i_speed[SPEED_W-1], i_speed};
        if (w_diff > DIFF_HI) begin
            w_err = DIFF_HI[ERR_W-1:0];
        end else if (w_diff < DIFF_LO) begin
            w_err = DIFF_LO[ERR_W-1:0];
        end else begin
            w_err = w_diff[ERR_W-1:0];
        end

        w_iprod = PROD_W'($signed({1'b0, i_gains.integ_gain})) * PROD_W'(w_err);
        w_pprod = PROD_W'($signed({1'b0, i_gains.prop_gain})) * PROD_W'(w_err);

        w_acc = {{(ACC_W-INTEG_W){r_int[INTEG_W-1]}}, r_int} + {w_iprod[PROD_W-1], w_iprod};
        if (w_acc > ACC_HI) begin
            n_int = ACC_HI[INTEG_W-1:0];
        end else if (w_acc < ACC_LO) begin
            n_int = ACC_LO[INTEG_W-1:0];
        end else begin
            n_int = w_acc[INTEG_W-1:0];
        end

        w_out = {{(OUT_W-INTEG_W){n_int[INTEG_W-1]}}, n_int}
              + {{(OUT_W-PROD_W){w_pprod[PROD_W-1]}}, w_pprod};
        if (w_out > OUT_HI) begin
            w_outc = OUT_HI;
        end else if (w_out < OUT_LO) begin
            w_outc = OUT_LO;
        end else begin
            w_outc = w_out;
        end

        w_neg   = w_outc[OUT_W-1];
        w_abs   = w_neg ? -w_outc : w_outc;
        w_mag   = w_abs[FRAC_SH +: MAG_W];
        w_pos   = {1'b0, w_mag};
        n_drive = w_neg ? -w_pos : w_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int   <= '0;
            r_drive <= '0;
        end else if (i_update) begin
            r_int   <= n_int;
            r_drive <= n_drive;
        end
    end

    assign o_drive = i_update ? n_drive : r_drive;

endmodule

`default_nettype wire

// ----- src/dwps_hbridge.sv -----
`default_nettype none

module dwps_hbridge #(
    parameter int unsigned PWM_MAX = dwps_pkg::PWM_MAX_DEF,
    localparam int DRV_W = $clog2(PWM_MAX + 1) + 1
) (
    input  wire logic signed [DRV_W-1:0]     i_drive,
    input  wire logic                        i_pos_on_one,
    output logic [dwps_pkg::CHAN_W-1:0]      o_chan_one,
    output logic [dwps_pkg::CHAN_W-1:0]      o_chan_two
);
    import dwps_pkg::*;

    localparam int MAG_W = DRV_W - 1;

    logic                      w_neg;
    logic [DRV_W-1:0]          w_abs;
    logic [CHAN_W+MAG_W-1:0]   w_ext;
    logic [CHAN_W-1:0]         w_val;
    logic                      w_first;

    always_comb begin
        w_neg   = i_drive[DRV_W-1];
        w_abs   = w_neg ? -i_drive : i_drive;
        w_ext   = {{CHAN_W{1'b0}}, w_abs[MAG_W-1:0]};
        w_val   = w_ext[CHAN_W-1:0];
        w_first = w_neg ? !i_pos_on_one : i_pos_on_one;
        o_chan_one = w_first ? w_val : '0;
        o_chan_two = w_first ? '0 : w_val;
    end

endmodule

`default_nettype wire
